// ----- src/inter_beat_interval_smoother_top_assert.svh -----
// Assertion macros for the inter-beat interval smoother.
// Included by inter_beat_interval_smoother_top, which carries concurrent checks; needs nothing else.
`ifndef INTER_BEAT_INTERVAL_SMOOTHER_TOP_ASSERT_SVH
`define INTER_BEAT_INTERVAL_SMOOTHER_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define IBIS_CHK_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define IBIS_CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ibis_pkg.sv -----
// Shared types, widths, status codes and sequencer states of the smoother.
// Used by ibis_div and inter_beat_interval_smoother_top; depends on nothing.
package ibis_pkg;

    localparam int unsigned MAX_BEATS_DEF = 64;
    localparam int unsigned ONSET_W       = 32;
    localparam int unsigned HW_W          = 6;
    localparam int unsigned DVS_W         = HW_W + 1;
    localparam int unsigned SUM_W         = 39;
    localparam int unsigned STEP_W        = $clog2(SUM_W);

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_FEW = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    localparam logic [HW_W-1:0] HW_RESET = 6'd2;

    typedef struct packed {
        logic [ONSET_W-1:0] onset;
        logic               last;
    } t_in;

    typedef struct packed {
        logic [ONSET_W-1:0] onset_out;
        logic               last_out;
        logic [1:0]         status;
    } t_out;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_st;

    typedef enum logic [3:0] {
        S_LOAD,
        S_DECIDE,
        S_PRD,
        S_PEMIT,
        S_WRD,
        S_WADD,
        S_FIRST,
        S_DSTART,
        S_DWAIT,
        S_NEW,
        S_EMIT,
        S_LORD,
        S_LOSUB,
        S_HIRD,
        S_HIADD
    } t_state;

endpackage

// ----- src/inter_beat_interval_smoother_top.sv -----
// Inter-beat interval smoother: onset store, gap store, window sequencer.
// Load: one item per cycle. A run too short or overflowed is replayed from the
// onset store; else 2h+1 gaps prime the window sum, then each interval is
// smoothed via the 39-step serial divider. Synchronous active-low reset clears
// the beat count and flags and sets half_width to 2; stores hold stale data.
// Depends on ibis_pkg, ibis_div and inter_beat_interval_smoother_top_assert.svh.
`include "inter_beat_interval_smoother_top_assert.svh"

module inter_beat_interval_smoother_top #(
    parameter int unsigned MAX_BEATS = ibis_pkg::MAX_BEATS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ibis_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ibis_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic signed [ibis_pkg::HW_W-1:0] i_cfg_data
);
    import ibis_pkg::*;

    localparam int unsigned AW = $clog2(MAX_BEATS);
    localparam int unsigned CW = $clog2(MAX_BEATS + 1);
    localparam int unsigned PW = ((AW > HW_W) ? AW : HW_W) + 2;
    localparam logic signed [PW-1:0] ONE_P  = 1;
    localparam logic signed [PW-1:0] ZERO_P = 0;

    logic [ONSET_W-1:0] store_mem [MAX_BEATS];
    logic [ONSET_W-1:0] gap_mem   [MAX_BEATS-1];

    t_state             r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_ovf, n_ovf;
    logic [ONSET_W-1:0] r_prev, n_prev;
    logic [ONSET_W-1:0] r_first, n_first;
    logic [HW_W-1:0]    r_hw;
    logic [CW-1:0]      r_k, n_k;
    logic signed [PW-1:0] r_pos, n_pos;
    logic [SUM_W-1:0]   r_sum, n_sum;
    logic [ONSET_W-1:0] r_run, n_run;
    logic [ONSET_W:0]   r_newgap, n_newgap;
    logic [1:0]         r_status, n_status;
    logic               r_ovalid, n_ovalid;
    t_out               r_opay, n_opay;
    logic [ONSET_W-1:0] r_srd, r_grd;

    logic               in_acc, out_free;
    logic               store_we, gap_we, store_re, gap_re;
    logic [AW-1:0]      s_raddr, g_raddr;
    logic [ONSET_W-1:0] wr_gap;
    logic               div_start;
    logic [ONSET_W-1:0] quot;
    t_div_st            div_st;

    logic [HW_W-1:0]    h_abs;
    logic               sharpen;
    logic [CW-1:0]      cm1, k_inc;
    logic signed [PW-1:0] sz_p, hp, ip;
    logic [ONSET_W:0]   twice;
    logic [ONSET_W+1:0] run_sum;
    logic [ONSET_W-1:0] run_sat;
    logic               emit_last;

    function automatic logic [AW-1:0] f_mirror(input logic signed [PW-1:0] pos,
                                               input logic signed [PW-1:0] sz);
        logic signed [PW-1:0] m;
        if (pos < ZERO_P)
            m = -pos - ONE_P;
        else if (pos >= sz)
            m = (sz <<< 1) - pos - ONE_P;
        else
            m = pos;
        return m[AW-1:0];
    endfunction

    assign sharpen  = r_hw[HW_W-1];
    assign h_abs    = sharpen ? (~r_hw + HW_W'(1)) : r_hw;
    assign cm1      = r_count - CW'(1);
    assign k_inc    = r_k + CW'(1);
    assign sz_p     = $signed({{(PW-CW){1'b0}}, cm1});
    assign hp       = $signed({{(PW-HW_W){1'b0}}, h_abs});
    assign ip       = $signed({{(PW-CW){1'b0}}, r_k});
    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign wr_gap   = (i_in_data.onset >= r_prev) ? (i_in_data.onset - r_prev) : '0;
    assign twice    = {r_grd, 1'b0};
    assign run_sum  = {2'b00, r_run} + {1'b0, r_newgap};
    assign run_sat  = (run_sum[ONSET_W+1:ONSET_W] != 2'b00) ? '1 : run_sum[ONSET_W-1:0];
    assign emit_last = (k_inc == cm1);

    ibis_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_sum),
        .i_divisor  ({h_abs, 1'b1}),
        .o_quot     (quot),
        .o_st       (div_st)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:   if (in_acc && i_in_data.last) n_state = S_DECIDE;
            S_DECIDE: n_state = (r_ovf || (sz_p <= hp)) ? S_PRD : S_WRD;
            S_PRD:    n_state = S_PEMIT;
            S_PEMIT: begin
                if (out_free) n_state = (r_k == cm1) ? S_LOAD : S_PRD;
            end
            S_WRD:    n_state = S_WADD;
            S_WADD:   n_state = (r_pos == hp) ? S_FIRST : S_WRD;
            S_FIRST:  if (out_free) n_state = S_DSTART;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT:  if (div_st.done) n_state = S_NEW;
            S_NEW:    n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) n_state = emit_last ? S_LOAD : S_LORD;
            end
            S_LORD:   n_state = S_LOSUB;
            S_LOSUB:  n_state = S_HIRD;
            S_HIRD:   n_state = S_HIADD;
            S_HIADD:  n_state = S_DSTART;
            default:  n_state = S_LOAD;
        endcase
    end

    always_comb begin
        store_we  = 1'b0;
        gap_we    = 1'b0;
        store_re  = 1'b0;
        gap_re    = 1'b0;
        s_raddr   = r_k[AW-1:0];
        g_raddr   = r_k[AW-1:0];
        div_start = 1'b0;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_prev    = r_prev;
        n_first   = r_first;
        n_k       = r_k;
        n_pos     = r_pos;
        n_sum     = r_sum;
        n_run     = r_run;
        n_newgap  = r_newgap;
        n_status  = r_status;
        n_ovalid  = r_ovalid && i_out_stall;
        n_opay    = r_opay;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CW'(MAX_BEATS)) begin
                        store_we = 1'b1;
                        gap_we   = (r_count != '0);
                        n_prev   = i_in_data.onset;
                        n_count  = r_count + CW'(1);
                        if (r_count == '0) n_first = i_in_data.onset;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_DECIDE: begin
                n_k      = '0;
                n_sum    = '0;
                n_pos    = -hp;
                n_status = r_ovf ? ST_OVF : ST_FEW;
            end
            S_PRD: store_re = 1'b1;
            S_PEMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_opay   = '{onset_out: r_srd, last_out: (r_k == cm1), status: r_status};
                    n_k      = k_inc;
                    if (r_k == cm1) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            S_WRD: begin
                gap_re  = 1'b1;
                g_raddr = f_mirror(r_pos, sz_p);
            end
            S_WADD: begin
                n_sum = r_sum + SUM_W'(r_grd);
                n_pos = r_pos + ONE_P;
            end
            S_FIRST: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_opay   = '{onset_out: r_first, last_out: 1'b0, status: ST_OK};
                    n_run    = r_first;
                end
            end
            S_DSTART: begin
                div_start = 1'b1;
                gap_re    = 1'b1;
            end
            S_NEW: begin
                if (sharpen)
                    n_newgap = (twice > {1'b0, quot}) ? (twice - {1'b0, quot}) : '0;
                else
                    n_newgap = {1'b0, quot};
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_opay   = '{onset_out: run_sat, last_out: emit_last, status: ST_OK};
                    n_run    = run_sat;
                    if (emit_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end
                end
            end
            S_LORD: begin
                gap_re  = 1'b1;
                g_raddr = f_mirror(ip - hp, sz_p);
            end
            S_LOSUB: n_sum = r_sum - SUM_W'(r_grd);
            S_HIRD: begin
                gap_re  = 1'b1;
                g_raddr = f_mirror(ip + hp + ONE_P, sz_p);
            end
            S_HIADD: begin
                n_sum = r_sum + SUM_W'(r_grd);
                n_k   = k_inc;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (store_we) store_mem[r_count[AW-1:0]] <= i_in_data.onset;
        if (gap_we)   gap_mem[cm1[AW-1:0]]       <= wr_gap;
        if (store_re) r_srd <= store_mem[s_raddr];
        if (gap_re)   r_grd <= gap_mem[g_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_hw     <= HW_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovf    <= n_ovf;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) r_hw <= i_cfg_data;
        end
        r_prev   <= n_prev;
        r_first  <= n_first;
        r_k      <= n_k;
        r_pos    <= n_pos;
        r_sum    <= n_sum;
        r_run    <= n_run;
        r_newgap <= n_newgap;
        r_status <= n_status;
        r_opay   <= n_opay;
    end

    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_opay;

    `IBIS_CHK_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_BEATS), "beat count beyond store depth")
    `IBIS_CHK_SAME(a_ovf_full, i_clk, i_rst_n, r_ovf, r_count == CW'(MAX_BEATS), "overflow with store not full")
    `IBIS_CHK_NEXT(a_last_decide, i_clk, i_rst_n, in_acc && i_in_data.last, r_state == S_DECIDE, "last item did not start the run")
    `IBIS_CHK_SAME(a_div_idle, i_clk, i_rst_n, div_start, !div_st.busy, "divider restarted while busy")

endmodule

// ----- src/ibis_div.sv -----
// Restoring divider of the window sum by 2h+1, one quotient bit per cycle.
// Depends on ibis_pkg for widths and the status struct.
module ibis_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ibis_pkg::SUM_W-1:0]      i_dividend,
    input  logic [ibis_pkg::DVS_W-1:0]      i_divisor,
    output logic [ibis_pkg::ONSET_W-1:0]    o_quot,
    output ibis_pkg::t_div_st               o_st
);
    import ibis_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_q, n_q;
    logic [DVS_W-1:0]  r_rem, n_rem;
    logic [DVS_W-1:0]  r_dvs, n_dvs;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              ge;

    assign trial = {r_rem, r_q[SUM_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_q    = r_q;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[SUM_W-2:0], ge};
            n_rem = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(SUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_quot    = r_q[ONSET_W-1:0];
    assign o_st.busy = r_busy;
    assign o_st.done = r_done;

endmodule

// ----- dv/inter_beat_interval_smoother_top_tb.sv -----
// Self-checking bench for inter_beat_interval_smoother_top: directed lists, then random
// lists over several half widths, checked item by item against an in-bench onset predictor.
// Depends on ibis_pkg and the smoother RTL only.
module inter_beat_interval_smoother_top_tb;
    import ibis_pkg::*;

    localparam int      DEPTH = MAX_BEATS_DEF;
    localparam int      DRAIN = 64;
    localparam int      HOLD  = 300;
    localparam longint  LIMIT = 400000;

    typedef enum logic [1:0] {
        R_BEAT,
        R_CHECKED,
        R_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic signed [5:0]  hw;
        logic [31:0]        onset;
        logic               last;
        logic [1:0]         exp_status;
    } t_row;

    localparam t_row PLAN [0:25] = '{
        '{R_CHECKED, 6'sd0, 32'h0000_0000, 1'b1, ST_FEW},
        '{R_CHECKED, 6'sd0, 32'hFFFF_FFFF, 1'b1, ST_FEW},
        '{R_BEAT,    6'sd0, 32'd10,        1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd20,        1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd30,        1'b1, ST_OK},
        '{R_BEAT,    6'sd0, 32'd0,         1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd100,       1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd250,       1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd260,       1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd900,       1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd1000,      1'b1, ST_OK},
        '{R_BEAT,    6'sd0, 32'd5000,      1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd4000,      1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd6000,      1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd7000,      1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd9000,      1'b1, ST_OK},
        '{R_CFG,     -6'sd1, 32'd0,        1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd0,         1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd1000,      1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd1001,      1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd1002,      1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'hFFFF_0000, 1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'hFFFF_FFFF, 1'b1, ST_OK},
        '{R_CFG,     6'sd0, 32'd0,         1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd7,         1'b0, ST_OK},
        '{R_BEAT,    6'sd0, 32'd3,         1'b1, ST_OK}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_stall = 1'b0;
    t_in                in_data = '0;
    logic               cfg_we = 1'b0;
    logic signed [5:0]  cfg_data = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out               o_out_data;

    logic [31:0]        beat_mem [DEPTH];
    int                 beat_n = 0;
    bit                 beat_ovf = 1'b0;
    logic signed [5:0]  width_reg = HW_RESET;

    t_out               onsets_due [$];
    t_out               onsets_new [$];
    int                 faults = 0;
    int                 beats_sent = 0;
    int                 onsets_checked = 0;
    int                 width_writes = 0;
    longint             cycles = 0;
    bit                 quiet = 1'b0;
    int                 hold_ask = 0;

    inter_beat_interval_smoother_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int fold(input int pos, input int sz);
        if (pos < 0) return -1 - pos;
        if (pos >= sz) return 2 * sz - pos - 1;
        return pos;
    endfunction

    function automatic void predict_onsets(input t_in item);
        int          sz;
        int          span;
        int          hw_i;
        bit          sharp;
        logic [63:0] acc;
        logic [63:0] mean;
        logic [63:0] twice;
        logic [63:0] run;
        logic [63:0] gaps [DEPTH];
        logic [63:0] smoothed [DEPTH];
        t_out        res;
        onsets_new.delete();
        if (beat_n < DEPTH) begin
            beat_mem[beat_n] = item.onset;
            beat_n++;
        end else begin
            beat_ovf = 1'b1;
        end
        if (!item.last) return;
        hw_i  = width_reg;
        sharp = hw_i < 0;
        span  = sharp ? -hw_i : hw_i;
        sz    = beat_n - 1;
        if (beat_ovf || sz <= span) begin
            for (int k = 0; k < beat_n; k++) begin
                res.onset_out = beat_mem[k];
                res.last_out  = (k == beat_n - 1);
                res.status    = beat_ovf ? ST_OVF : ST_FEW;
                onsets_new.push_back(res);
            end
        end else begin
            for (int i = 0; i < sz; i++) begin
                gaps[i] = (beat_mem[i + 1] >= beat_mem[i]) ?
                          64'(beat_mem[i + 1] - beat_mem[i]) : 64'd0;
            end
            for (int i = 0; i < sz; i++) begin
                acc = '0;
                for (int k = i - span; k <= i + span; k++) acc += gaps[fold(k, sz)];
                mean = acc / 64'(2 * span + 1);
                if (sharp) begin
                    twice       = gaps[i] << 1;
                    smoothed[i] = (twice > mean) ? twice - mean : 64'd0;
                end else begin
                    smoothed[i] = mean;
                end
            end
            run = 64'(beat_mem[0]);
            for (int k = 0; k <= sz; k++) begin
                if (k > 0) begin
                    run += smoothed[k - 1];
                    if (run > 64'hFFFF_FFFF) run = 64'hFFFF_FFFF;
                end
                res.onset_out = run[31:0];
                res.last_out  = (k == sz);
                res.status    = ST_OK;
                onsets_new.push_back(res);
            end
        end
        beat_n   = 0;
        beat_ovf = 1'b0;
    endfunction

    task automatic flag_fault(input string what);
        $display("mismatch at cycle %0d: %s", cycles, what);
        faults++;
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 19);
        if (r < 11) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer_beat(input logic [31:0] onset, input logic last,
                              input bit typed, input t_out typed_res);
        t_in item;
        int  gap;
        item.onset = onset;
        item.last  = last;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (o_in_stall);
        predict_onsets(item);
        if (typed) onsets_due.push_back(typed_res);
        else foreach (onsets_new[k]) onsets_due.push_back(onsets_new[k]);
        beats_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic offer_list(input int len);
        logic [31:0] t;
        int          shape;
        int          r;
        shape = $urandom_range(0, 9);
        case (shape)
            0, 1:    t = $urandom;
            2:       t = 32'hFFF0_0000 + $urandom_range(0, 32'h000F_FFFF);
            default: t = $urandom_range(0, 32'h00FF_FFFF);
        endcase
        for (int k = 0; k < len; k++) begin
            offer_beat(t, k == len - 1, 1'b0, '0);
            r = $urandom_range(0, 15);
            case (shape)
                0:       t = $urandom;
                1:       t = t + $urandom;
                2:       t = t + $urandom_range(0, 32'h0004_0000);
                default: begin
                    if (r == 0) t = t - $urandom_range(1, 5000);
                    else if (r != 1) t = t + $urandom_range(400000, 700000);
                end
            endcase
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (onsets_due.size() != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_width(input logic signed [5:0] hw);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= hw;
        @(posedge clk);
        cfg_we    <= 1'b0;
        width_reg = hw;
        width_writes++;
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d onsets outstanding", cycles,
                     onsets_due.size());
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge clk) begin
        t_out want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (onsets_due.size() == 0) begin
                flag_fault($sformatf("unexpected item, onset_out %h", o_out_data.onset_out));
            end else begin
                want = onsets_due.pop_front();
                onsets_checked++;
                if (o_out_data.onset_out !== want.onset_out)
                    flag_fault($sformatf("onset_out %h, want %h",
                                         o_out_data.onset_out, want.onset_out));
                if (o_out_data.last_out !== want.last_out)
                    flag_fault($sformatf("last_out %b, want %b",
                                         o_out_data.last_out, want.last_out));
                if (o_out_data.status !== want.status)
                    flag_fault($sformatf("status %0d, want %0d",
                                         o_out_data.status, want.status));
            end
        end
    end

    always @(posedge clk) begin
        static int hold_seen = 0;
        static int hold_left = 0;
        static int run_left  = 0;
        static bit stalling  = 1'b0;
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            if (run_left == 0) begin
                stalling = !quiet && ($urandom_range(0, 3) == 0);
                if (!stalling) run_left = $urandom_range(1, 8);
                else if ($urandom_range(0, 7) == 0) run_left = $urandom_range(10, 40);
                else run_left = $urandom_range(1, 4);
            end
            run_left--;
            out_stall <= stalling;
        end
    end

    initial begin
        t_out exp_row;
        int   phase_hw [0:6];
        int   p;
        phase_hw = '{31, -32, 0, 1, -31, 5, -3};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (PLAN[r]) begin
            case (PLAN[r].kind)
                R_CFG: write_width(PLAN[r].hw);
                R_CHECKED: begin
                    exp_row.onset_out = PLAN[r].onset;
                    exp_row.last_out  = 1'b1;
                    exp_row.status    = PLAN[r].exp_status;
                    offer_beat(PLAN[r].onset, PLAN[r].last, 1'b1, exp_row);
                end
                default: offer_beat(PLAN[r].onset, PLAN[r].last, 1'b0, '0);
            endcase
        end

        for (p = 0; p < 8; p++) begin
            write_width((p < 7) ? 6'(phase_hw[p]) : 6'($urandom_range(0, 63)));
            quiet <= (p == 2) || ($urandom_range(0, 4) == 0);
            case (p)
                0: offer_list($urandom_range(33, 36));
                1: offer_list($urandom_range(34, 37));
                3: begin
                    offer_list($urandom_range(65, 68));
                    hold_ask <= hold_ask + 1;
                end
                default: ;
            endcase
            offer_list($urandom_range(1, 8));
        end

        settle();
        $display("%0d onsets offered, %0d rebuilt onsets checked, %0d half-width writes",
                 beats_sent, onsets_checked, width_writes);
        $display("covered smoothing, sharpening, too-few and overflowed lists, output hold-off");
        if (faults == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
